// ===== hw/rtl/cfdms_pkg.sv =====
// Package for the mismatch score pipeline: fixed-point widths, the default
// weight table in hundredths and the per-position weight table builder.
// Used by cfd_mismatch_score; depends on nothing else.
package cfdms_pkg;

	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned SCORE_W = FRAC_BITS + 1;
	localparam int unsigned MAX_BASES_DEF = 32;
	localparam int unsigned POSITION_WEIGHTS_DEF = 20;
	localparam int unsigned ROM_POS = 20;
	localparam int unsigned ROM_DEPTH = 36;
	localparam int unsigned DEFAULT_POS_HUNDREDTHS = 70;
	localparam int unsigned PAIR_CODES = 16;

	localparam int unsigned LEN_W = 6;
	localparam int unsigned BASES_W = 64;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic {
		REG_CMP_LEN = 1'b0,
		REG_UNUSED = 1'b1
	} reg_index_t;

	localparam logic [LEN_W-1:0] CMP_LEN_RESET = LEN_W'(20);

	typedef logic [SCORE_W-1:0] weight_t;
	typedef logic [PAIR_CODES-1:0][SCORE_W-1:0] lane_table_t;

	localparam weight_t SCORE_ONE = weight_t'(1) << FRAC_BITS;

	// Entries 0 to 19 are position weights, entries 20 + 4*g + s are the
	// guide-to-site type weights.
	localparam int unsigned HUNDREDTHS [ROM_DEPTH] = '{
		61, 61, 62, 63, 64, 65, 66, 67, 68, 69,
		70, 71, 72, 74, 76, 78, 80, 83, 86, 90,
		100, 97, 48, 88,
		87, 100, 55, 73,
		14, 34, 100, 3,
		76, 67, 32, 100
	};

	function automatic logic [63:0] to_fixed(input int unsigned hundredths);
		logic [63:0] scaled;
		scaled = (64'(hundredths) << FRAC_BITS) + 64'd50;
		return scaled / 64'd100;
	endfunction

	// Combined weight of one position for all sixteen guide/site base pairs.
	function automatic lane_table_t lane_table(input int unsigned pos,
		input int unsigned pos_weights);
		lane_table_t tbl;
		logic [63:0] pos_w;
		logic [63:0] type_w;
		logic [63:0] prod;
		int unsigned pos_h;
		if (pos < pos_weights && pos < ROM_POS) begin
			pos_h = HUNDREDTHS[pos];
		end else begin
			pos_h = DEFAULT_POS_HUNDREDTHS;
		end
		pos_w = to_fixed(pos_h);
		for (int i = 0; i < int'(PAIR_CODES); i++) begin
			type_w = to_fixed(HUNDREDTHS[ROM_POS + i]);
			prod = (pos_w * type_w) >> FRAC_BITS;
			tbl[i] = prod[SCORE_W-1:0];
		end
		return tbl;
	endfunction

endpackage

// ===== hw/rtl/cfd_mismatch_score.sv =====
// Mismatch score pipeline: compares a guide with a candidate site and
// multiplies the weights of all mismatching positions into one score.
// Depends on cfdms_pkg for widths, constants and the weight tables.
//
// One guide/site pair enters per clock cycle unless the output side stalls,
// and its score passes the first stage and then every weight stage. The first
// stage aligns the bases to the compare length and marks mismatches; each of the
// following MAX_BASES stages owns one base position and holds one 17 by 17 bit
// multiplier, so the pipeline depth follows the number of positions. Each stage
// advances on its own, so bubbles are squeezed out while the output waits.
// The score is unsigned with 16 fraction bits; 65536 stands for 1.0 and each
// product is truncated. The compare length register sits at byte address 0
// of the configuration port, is clamped to MAX_BASES and must only change
// while no transaction is in flight.
module cfd_mismatch_score #(
	parameter int unsigned MAX_BASES = cfdms_pkg::MAX_BASES_DEF,
	parameter int unsigned POSITION_WEIGHTS = cfdms_pkg::POSITION_WEIGHTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [cfdms_pkg::PADDR_W-1:0]    paddr,
	input  logic [cfdms_pkg::PDATA_W-1:0]    pwdata,
	output logic [cfdms_pkg::PDATA_W-1:0]    prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [cfdms_pkg::BASES_W-1:0]    guide_bases,
	input  logic [cfdms_pkg::BASES_W-1:0]    site_bases,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [cfdms_pkg::SCORE_W-1:0]    score
);

	localparam int unsigned LAST = MAX_BASES;
	localparam int unsigned SHAMT_W = 7;

	logic [cfdms_pkg::LEN_W-1:0] cmp_len_q;
	cfdms_pkg::reg_index_t       reg_sel;

	logic [LAST:0] valid_sk;
	logic [LAST:0] stage_en;

	logic [MAX_BASES-1:0][3:0]   pair_sk [MAX_BASES];
	logic [MAX_BASES-1:0]        miss_sk [MAX_BASES];
	logic [cfdms_pkg::SCORE_W-1:0] score_sk [1:LAST];

	logic [cfdms_pkg::LEN_W-1:0]   len_clamp;
	logic [SHAMT_W-1:0]            shamt;
	logic [cfdms_pkg::BASES_W-1:0] guide_al;
	logic [cfdms_pkg::BASES_W-1:0] site_al;
	logic [MAX_BASES-1:0][3:0]     pair_d;
	logic [MAX_BASES-1:0]          miss_d;

	// Configuration port.
	assign pready = 1'b1;
	assign reg_sel = cfdms_pkg::reg_index_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_len_q <= cfdms_pkg::CMP_LEN_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				cfdms_pkg::REG_CMP_LEN: cmp_len_q <= pwdata[cfdms_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			cfdms_pkg::REG_CMP_LEN: begin
				prdata = {{(cfdms_pkg::PDATA_W - cfdms_pkg::LEN_W){1'b0}}, cmp_len_q};
			end
			default: prdata = '0;
		endcase
	end

	// Per-stage flow control: a stage loads when it is empty or its successor loads.
	assign stage_en[LAST] = !valid_sk[LAST] || out_ready;
	for (genvar k = 0; k < int'(LAST); k++) begin : g_en
		assign stage_en[k] = !valid_sk[k] || stage_en[k+1];
	end

	assign in_ready = stage_en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sk[0] <= 1'b0;
		end else if (stage_en[0]) begin
			valid_sk[0] <= in_valid;
		end
	end

	for (genvar k = 1; k <= int'(LAST); k++) begin : g_valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[k] <= 1'b0;
			end else if (stage_en[k]) begin
				valid_sk[k] <= valid_sk[k-1];
			end
		end
	end

	// Stage 0: align position 0 to the top of the used bases and mark mismatches.
	always_comb begin
		if (cmp_len_q > cfdms_pkg::LEN_W'(MAX_BASES)) begin
			len_clamp = cfdms_pkg::LEN_W'(MAX_BASES);
		end else begin
			len_clamp = cmp_len_q;
		end
		shamt = SHAMT_W'(2 * MAX_BASES) - {len_clamp, 1'b0};
		guide_al = guide_bases << shamt;
		site_al = site_bases << shamt;
		for (int p = 0; p < int'(MAX_BASES); p++) begin
			pair_d[p] = {guide_al[2*MAX_BASES-1-2*p -: 2], site_al[2*MAX_BASES-1-2*p -: 2]};
			miss_d[p] = (len_clamp > cfdms_pkg::LEN_W'(p)) &&
				(guide_al[2*MAX_BASES-1-2*p -: 2] != site_al[2*MAX_BASES-1-2*p -: 2]);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			pair_sk[0] <= pair_d;
			miss_sk[0] <= miss_d;
		end
	end

	// Stage j multiplies in the weight of base position j-1.
	for (genvar j = 1; j <= int'(LAST); j++) begin : g_mul
		localparam cfdms_pkg::lane_table_t LANE_W =
			cfdms_pkg::lane_table(j - 1, POSITION_WEIGHTS);

		logic [cfdms_pkg::SCORE_W-1:0]     score_in;
		logic [cfdms_pkg::SCORE_W-1:0]     weight;
		logic [2*cfdms_pkg::SCORE_W-1:0]   prod;
		logic [cfdms_pkg::SCORE_W-1:0]     score_d;

		if (j == 1) begin : g_first
			assign score_in = cfdms_pkg::SCORE_ONE;
		end else begin : g_next
			assign score_in = score_sk[j-1];
		end

		assign weight = LANE_W[pair_sk[j-1][j-1]];
		assign prod = score_in * weight;
		assign score_d = miss_sk[j-1][j-1] ?
			prod[cfdms_pkg::FRAC_BITS +: cfdms_pkg::SCORE_W] : score_in;

		always_ff @(posedge clk) begin
			if (stage_en[j]) begin
				score_sk[j] <= score_d;
			end
		end

		if (j < int'(LAST)) begin : g_carry
			always_ff @(posedge clk) begin
				if (stage_en[j]) begin
					pair_sk[j] <= pair_sk[j-1];
					miss_sk[j] <= miss_sk[j-1];
				end
			end
		end
	end

	assign out_valid = valid_sk[LAST];
	assign score = score_sk[LAST];

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for cfd_mismatch_score: drives guide/site pairs with
// random bursts and gaps, stalls the score output and checks every score.
// Depends on cfdms_pkg and cfd_mismatch_score only.
module tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = cfdms_pkg::MAX_BASES_DEF + 8;
	localparam int unsigned SCORED_POSITIONS = 20;
	localparam int unsigned FAR_POS_HUNDREDTHS = 70;
	localparam logic [cfdms_pkg::PADDR_W-1:0] CMP_LEN_ADDR =
		cfdms_pkg::PADDR_W'(4 * int'(cfdms_pkg::REG_CMP_LEN));

	localparam int unsigned POS_HUNDREDTHS [SCORED_POSITIONS] = '{
		61, 61, 62, 63, 64, 65, 66, 67, 68, 69,
		70, 71, 72, 74, 76, 78, 80, 83, 86, 90
	};
	localparam int unsigned PAIR_HUNDREDTHS [16] = '{
		100, 97, 48, 88,
		87, 100, 55, 73,
		14, 34, 100, 3,
		76, 67, 32, 100
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [cfdms_pkg::PADDR_W-1:0] paddr = '0;
	logic [cfdms_pkg::PDATA_W-1:0] pwdata = '0;
	logic [cfdms_pkg::PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [cfdms_pkg::BASES_W-1:0] guide_bases = '0;
	logic [cfdms_pkg::BASES_W-1:0] site_bases = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [cfdms_pkg::SCORE_W-1:0] score;

	logic [cfdms_pkg::SCORE_W-1:0] pending_scores [$];
	logic [cfdms_pkg::SCORE_W-1:0] wanted_score;
	logic [cfdms_pkg::LEN_W-1:0] guide_len_cfg = cfdms_pkg::CMP_LEN_RESET;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 1;
	int unsigned stall_window = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_tick = 0;

	cfd_mismatch_score u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.guide_bases(guide_bases),
		.site_bases (site_bases),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.score      (score)
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] weight_q16(input int unsigned hundredths);
		return ((64'(hundredths) << 16) + 64'd50) / 64'd100;
	endfunction

	function automatic int unsigned compared_bases(input logic [cfdms_pkg::LEN_W-1:0] len);
		return (len > cfdms_pkg::MAX_BASES_DEF) ? cfdms_pkg::MAX_BASES_DEF : int'(len);
	endfunction

	function automatic logic [cfdms_pkg::SCORE_W-1:0] mismatch_score(
		input logic [cfdms_pkg::BASES_W-1:0] g, input logic [cfdms_pkg::BASES_W-1:0] s,
		input logic [cfdms_pkg::LEN_W-1:0] len_cfg);
		int unsigned len;
		int unsigned sh;
		logic [1:0] gb;
		logic [1:0] sb;
		logic [63:0] acc;
		logic [63:0] pos_w;
		logic [63:0] pair_w;
		logic [63:0] w;
		len = compared_bases(len_cfg);
		acc = 64'd1 << 16;
		for (int unsigned p = 0; p < len; p++) begin
			sh = 2 * (len - 1 - p);
			gb = g[sh +: 2];
			sb = s[sh +: 2];
			if (gb != sb) begin
				if (p < SCORED_POSITIONS) begin
					pos_w = weight_q16(POS_HUNDREDTHS[p]);
				end else begin
					pos_w = weight_q16(FAR_POS_HUNDREDTHS);
				end
				pair_w = weight_q16(PAIR_HUNDREDTHS[{gb, sb}]);
				w = (pos_w * pair_w) >> 16;
				acc = (acc * w) >> 16;
			end
		end
		return acc[cfdms_pkg::SCORE_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic send_pair(input logic [cfdms_pkg::BASES_W-1:0] g,
		input logic [cfdms_pkg::BASES_W-1:0] s);
		int unsigned gap;
		guide_bases <= g;
		site_bases <= s;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_scores.insert(pending_scores.size(), mismatch_score(g, s, guide_len_cfg));
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_cmp_len(input logic [cfdms_pkg::LEN_W-1:0] len);
		in_valid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CMP_LEN_ADDR;
		pwdata <= cfdms_pkg::PDATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		guide_len_cfg = len;
	endtask

	task automatic test_reset_length_cases();
		send_pair('0, '0);
		send_pair('1, '1);
		send_pair('0, '1);
		send_pair(64'h0000_0000_000A_AAAA, 64'h0000_0000_0005_5555);
		send_pair(64'h0000_0000_0000_0003, 64'h0000_0000_0000_0000);
		send_pair(64'hFFFF_FF00_0000_0000, 64'h0000_00FF_0000_0000);
	endtask

	task automatic test_pair_types();
		logic [cfdms_pkg::BASES_W-1:0] g;
		logic [cfdms_pkg::BASES_W-1:0] s;
		int unsigned k;
		for (int unsigned i = 0; i < 16; i++) begin
			k = SCORED_POSITIONS - 1 - i;
			g = '0;
			s = '0;
			g[2*k +: 2] = i[3:2];
			s[2*k +: 2] = i[1:0];
			send_pair(g, s);
		end
	endtask

	task automatic test_length_extremes();
		write_cmp_len(cfdms_pkg::LEN_W'(0));
		send_pair('1, '0);
		write_cmp_len(cfdms_pkg::LEN_W'(1));
		send_pair(64'h0000_0000_0000_0002, 64'hFFFF_FFFF_FFFF_FFFF);
		write_cmp_len(cfdms_pkg::LEN_W'(32));
		send_pair('0, '1);
		write_cmp_len(cfdms_pkg::LEN_W'(33));
		send_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		write_cmp_len(cfdms_pkg::LEN_W'(63));
		send_pair(64'h8000_0000_0000_0001, 64'h0000_0000_0000_0000);
	endtask

	task automatic test_random_traffic(input logic [cfdms_pkg::LEN_W-1:0] len,
		input int unsigned count);
		logic [cfdms_pkg::BASES_W-1:0] g;
		logic [cfdms_pkg::BASES_W-1:0] s;
		logic [cfdms_pkg::BASES_W-1:0] noise;
		int unsigned span;
		int unsigned kind;
		int unsigned flips;
		int unsigned k;
		write_cmp_len(len);
		span = compared_bases(len);
		for (int unsigned n = 0; n < count; n++) begin
			g = {$urandom, $urandom};
			kind = $urandom_range(0, 9);
			if (kind < 6 && span != 0) begin
				s = g;
				flips = $urandom_range(0, 4);
				for (int unsigned f = 0; f < flips; f++) begin
					k = $urandom_range(0, span - 1);
					s[2*k +: 2] = s[2*k +: 2] ^ 2'($urandom_range(1, 3));
				end
			end else if (kind < 8) begin
				s = {$urandom, $urandom};
			end else begin
				noise = {$urandom, $urandom};
				if (span != 0) begin
					noise = noise & ~((64'd1 << (2 * span - 1) << 1) - 64'd1);
				end
				s = g ^ noise;
				if (span != 0 && $urandom_range(0, 1) == 1) begin
					k = $urandom_range(0, span - 1);
					s[2*k +: 2] = ~s[2*k +: 2];
				end
			end
			send_pair(g, s);
		end
	endtask

	always @(posedge clk) begin
		if (stall_window == 0) begin
			stall_window = $urandom_range(40, 300);
			stall_mode = $urandom_range(0, 3);
		end else begin
			stall_window--;
		end
		stall_tick++;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= (stall_tick % 5 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_scores.size() == 0) begin
				report_mismatch($sformatf("score %0d with no pending transaction", score));
			end else begin
				wanted_score = pending_scores.pop_front();
				if (score !== wanted_score) begin
					report_mismatch($sformatf("score %0d, expected %0d", score, wanted_score));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_length_cases();
		test_pair_types();
		test_length_extremes();
		test_random_traffic(cfdms_pkg::LEN_W'(20), 160);
		test_random_traffic(cfdms_pkg::LEN_W'(32), 160);
		test_random_traffic(cfdms_pkg::LEN_W'(1), 80);
		test_random_traffic(cfdms_pkg::LEN_W'(7), 100);
		test_random_traffic(cfdms_pkg::LEN_W'(33), 100);
		test_random_traffic(cfdms_pkg::LEN_W'(0), 40);
		test_random_traffic(cfdms_pkg::LEN_W'(63), 100);
		test_random_traffic(cfdms_pkg::LEN_W'(13), 100);
		test_random_traffic(cfdms_pkg::LEN_W'(25), 120);
		test_random_traffic(cfdms_pkg::LEN_W'(2), 80);
		test_random_traffic(cfdms_pkg::LEN_W'(31), 120);
		test_random_traffic(cfdms_pkg::LEN_W'(20), 140);
		in_valid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_scores.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
